>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MMLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MMLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mmlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmlp_pkg;

    localparam int NAME_CAPACITY_DEF = 1024;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_W       = 8'h77;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] HEX_LOWER_BASE = CH_LA - 8'd10;
    localparam logic [7:0] HEX_UPPER_BASE = CH_UA - 8'd10;

    localparam logic KIND_ECHO   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_EOD = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    typedef enum logic [13:0] {
        PH_START  = 14'b00000000000001,
        PH_END    = 14'b00000000000010,
        PH_PR     = 14'b00000000000100,
        PH_PW     = 14'b00000000001000,
        PH_PX     = 14'b00000000010000,
        PH_SHARE  = 14'b00000000100000,
        PH_SP     = 14'b00000001000000,
        PH_OFFSET = 14'b00000010000000,
        PH_MAJOR  = 14'b00000100000000,
        PH_MINOR  = 14'b00001000000000,
        PH_INODE  = 14'b00010000000000,
        PH_GAP    = 14'b00100000000000,
        PH_NAME   = 14'b01000000000000,
        PH_SKIP   = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        logic        result_kind;
        logic [63:0] region_start;
        logic [63:0] region_size;
        logic [63:0] file_offset;
        logic [2:0]  perm_bits;
        logic [2:0]  map_flags;
        logic [31:0] dev_major;
        logic [31:0] dev_minor;
        logic [63:0] inode_number;
        logic [9:0]  name_length;
        logic [7:0]  name_char;
        logic [1:0]  status;
    } result_t;

    // {is_hex, value}
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[CH_0:CH_9]})
            r = {1'b1, 4'(c - CH_0)};
        else if (c inside {[CH_LA:CH_LF]})
            r = {1'b1, 4'(c - HEX_LOWER_BASE)};
        else if (c inside {[CH_UA:CH_UF]})
            r = {1'b1, 4'(c - HEX_UPPER_BASE)};
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mmlp_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mmlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/mmlp_rec_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mmlp_rec_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [63:0] region_start;
    logic [63:0] region_size;
    logic [63:0] file_offset;
    logic [2:0]  perm_bits;
    logic [2:0]  map_flags;
    logic [31:0] dev_major;
    logic [31:0] dev_minor;
    logic [63:0] inode_number;
    logic [9:0]  name_length;
    logic [7:0]  name_char;
    logic [1:0]  status;

    modport source (
        output valid, output result_kind, output region_start, output region_size,
        output file_offset, output perm_bits, output map_flags, output dev_major,
        output dev_minor, output inode_number, output name_length, output name_char,
        output status, input ready
    );
    modport sink (
        input valid, input result_kind, input region_start, input region_size,
        input file_offset, input perm_bits, input map_flags, input dev_major,
        input dev_minor, input inode_number, input name_length, input name_char,
        input status, output ready
    );
endinterface

`default_nettype wire

>>> rtl/memory_map_line_parser.sv
// memory map line parser
// byte_chan (sink) takes the listing text, one byte per item; a zero byte
// marks end of input. rec_chan (source) gives one item per echoed name
// byte or per finished line (record, end of data or malformed line).
// a byte is held in the input register and its result, if any, is
// registered in the result register in the step that consumes the byte.
// one byte is taken every cycle while rec_chan is not stalled, the parse
// state being updated by a single pass of logic between the two registers.
// a malformed line gives its error record at once and the rest of the
// line up to newline or zero is dropped without results.
// reset (rst_n, async, active low) empties both registers and puts the
// parser at the start of a line with all fields cleared.
// when the receiver stalls, the result register holds and the input
// register takes a byte only if it is empty; once it is full,
// byte_chan.ready stays low until rec_chan.ready returns.
`timescale 1ns / 1ps
`default_nettype none

module memory_map_line_parser #(
    parameter int NAME_CAPACITY = mmlp_pkg::NAME_CAPACITY_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mmlp_byte_if.sink  byte_chan,
    mmlp_rec_if.source rec_chan
);
    import mmlp_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       can_take;
    logic       step;
    logic       res_valid;
    result_t    res;

    assign step = held_valid && can_take;

    mmlp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_chan  (byte_chan),
        .take       (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    mmlp_parse_core #(
        .NAME_CAPACITY (NAME_CAPACITY)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .c         (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    mmlp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .can_take (can_take),
        .rec_chan (rec_chan)
    );

endmodule

`default_nettype wire

>>> rtl/mmlp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module mmlp_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mmlp_byte_if.sink       byte_chan,
    input  wire logic       take,
    output logic            held_valid,
    output logic [7:0]      held_byte
);
    import mmlp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign byte_chan.ready = !valid_reg || take;
    assign load            = byte_chan.valid && byte_chan.ready;
    assign valid_next      = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_chan.in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

>>> rtl/mmlp_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mmlp_parse_core #(
    parameter int NAME_CAPACITY = mmlp_pkg::NAME_CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  c,
    output logic             res_valid,
    output mmlp_pkg::result_t res
);
    import mmlp_pkg::*;

    localparam int CNT_W = $clog2(NAME_CAPACITY + 1);

    phase_t           phase_reg, phase_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      start_reg, start_next;
    logic [63:0]      end_reg, end_next;
    logic [63:0]      offset_reg, offset_next;
    logic [31:0]      major_reg, major_next;
    logic [31:0]      minor_reg, minor_next;
    logic [2:0]       perm_reg, perm_next;
    logic             share_reg, share_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [4:0]       hex;
    logic             is_dec;
    logic [3:0]       dec;
    logic [63:0]      acc_hex;
    logic [63:0]      acc_dec;
    logic [CNT_W-1:0] count_inc;
    logic             is_nl;
    logic             is_nul;
    logic             do_gap;
    logic             do_name;
    logic             do_finish;
    logic             do_fail;
    logic             do_begin;

    assign hex       = hex_digit(c);
    assign is_dec    = (c >= CH_0) && (c <= CH_9);
    assign dec       = 4'(c - CH_0);
    assign acc_hex   = {acc_reg[59:0], hex[3:0]};
    assign acc_dec   = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0} + {60'd0, dec};
    assign count_inc = count_reg + 1'b1;
    assign is_nl     = (c == CH_NL);
    assign is_nul    = (c == CH_NUL);

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        offset_next = offset_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        perm_next   = perm_reg;
        share_next  = share_reg;
        count_next  = count_reg;
        res         = '0;
        res_valid   = 1'b0;
        do_gap      = 1'b0;
        do_name     = 1'b0;
        do_finish   = 1'b0;
        do_fail     = 1'b0;
        do_begin    = 1'b0;

        case (phase_reg)
            PH_START:
            begin
                if (hex[4])
                    acc_next = acc_hex;
                else if (c == CH_DASH)
                begin
                    start_next = acc_reg;
                    acc_next   = '0;
                    phase_next = PH_END;
                end
                else if (is_nul && acc_reg == '0)
                begin
                    res_valid          = 1'b1;
                    res.result_kind    = KIND_RECORD;
                    res.status         = ST_EOD;
                    do_begin           = 1'b1;
                end
                else
                    do_fail = 1'b1;
            end
            PH_END:
            begin
                if (hex[4])
                    acc_next = acc_hex;
                else if (c != CH_SPACE || acc_reg < start_reg)
                    do_fail = 1'b1;
                else
                begin
                    end_next   = acc_reg;
                    acc_next   = '0;
                    phase_next = PH_PR;
                end
            end
            PH_PR:
            begin
                phase_next = PH_PW;
                if (c == CH_R)
                    perm_next[0] = 1'b1;
                else if (c != CH_DASH)
                    do_fail = 1'b1;
            end
            PH_PW:
            begin
                phase_next = PH_PX;
                if (c == CH_W)
                    perm_next[1] = 1'b1;
                else if (c != CH_DASH)
                    do_fail = 1'b1;
            end
            PH_PX:
            begin
                phase_next = PH_SHARE;
                if (c == CH_X)
                    perm_next[2] = 1'b1;
                else if (c != CH_DASH)
                    do_fail = 1'b1;
            end
            PH_SHARE:
            begin
                phase_next = PH_SP;
                if (c == CH_S)
                    share_next = 1'b1;
                else if (c == CH_P)
                    share_next = 1'b0;
                else
                    do_fail = 1'b1;
            end
            PH_SP:
            begin
                if (c != CH_SPACE)
                    do_fail = 1'b1;
                else
                begin
                    acc_next   = '0;
                    phase_next = PH_OFFSET;
                end
            end
            PH_OFFSET:
            begin
                if (hex[4])
                    acc_next = acc_hex;
                else if (c != CH_SPACE)
                    do_fail = 1'b1;
                else
                begin
                    offset_next = acc_reg;
                    acc_next    = '0;
                    phase_next  = PH_MAJOR;
                end
            end
            PH_MAJOR:
            begin
                if (hex[4])
                    acc_next = acc_hex;
                else if (c != CH_COLON)
                    do_fail = 1'b1;
                else
                begin
                    major_next = acc_reg[31:0];
                    acc_next   = '0;
                    phase_next = PH_MINOR;
                end
            end
            PH_MINOR:
            begin
                if (hex[4])
                    acc_next = acc_hex;
                else if (c != CH_SPACE)
                    do_fail = 1'b1;
                else
                begin
                    minor_next = acc_reg[31:0];
                    acc_next   = '0;
                    phase_next = PH_INODE;
                end
            end
            PH_INODE:
            begin
                if (is_dec)
                    acc_next = acc_dec;
                else
                    do_gap = 1'b1;
            end
            PH_GAP:
            begin
                do_gap = 1'b1;
            end
            PH_NAME:
            begin
                if (is_nl)
                    do_finish = 1'b1;
                else if (is_nul)
                    do_fail = 1'b1;
                else
                    do_name = 1'b1;
            end
            PH_SKIP:
            begin
                if (is_nl || is_nul)
                    do_begin = 1'b1;
            end
            default:
            begin
                do_begin = 1'b1;
            end
        endcase

        // separator run between inode and name
        if (do_gap)
        begin
            if (c == CH_SPACE)
                phase_next = PH_GAP;
            else if (c == CH_SLASH || c == CH_LBRACK)
                do_name = 1'b1;
            else if (is_nl)
                do_finish = 1'b1;
            else
                do_fail = 1'b1;
        end

        if (do_name)
        begin
            count_next = count_inc;
            if (count_inc >= CNT_W'(NAME_CAPACITY))
                do_fail = 1'b1;
            else
            begin
                phase_next      = PH_NAME;
                res_valid       = 1'b1;
                res.result_kind = KIND_ECHO;
                res.name_length = 10'(count_inc);
                res.name_char   = c;
            end
        end

        if (do_finish)
        begin
            res_valid        = 1'b1;
            res.result_kind  = KIND_RECORD;
            res.region_start = start_reg;
            res.region_size  = end_reg - start_reg;
            res.file_offset  = offset_reg;
            res.perm_bits    = perm_reg;
            res.map_flags    = {count_reg == '0, !share_reg, share_reg};
            res.dev_major    = major_reg;
            res.dev_minor    = minor_reg;
            res.inode_number = acc_reg;
            res.name_length  = 10'(count_reg);
            res.status       = ST_OK;
            do_begin         = 1'b1;
        end

        if (do_fail)
        begin
            res             = '0;
            res_valid       = 1'b1;
            res.result_kind = KIND_RECORD;
            res.status      = ST_BAD;
            if (is_nl || is_nul)
                do_begin = 1'b1;
            else
                phase_next = PH_SKIP;
        end

        if (do_begin)
        begin
            phase_next = PH_START;
            acc_next   = '0;
            perm_next  = '0;
            share_next = 1'b0;
            count_next = '0;
        end

        if (!step)
            res_valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            acc_reg    <= '0;
            start_reg  <= '0;
            end_reg    <= '0;
            offset_reg <= '0;
            major_reg  <= '0;
            minor_reg  <= '0;
            perm_reg   <= '0;
            share_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            start_reg  <= start_next;
            end_reg    <= end_next;
            offset_reg <= offset_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            perm_reg   <= perm_next;
            share_reg  <= share_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mmlp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module mmlp_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire mmlp_pkg::result_t res,
    output logic                   can_take,
    mmlp_rec_if.source             rec_chan
);
    import mmlp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_take   = !valid_reg || rec_chan.ready;
    assign valid_next = load || (valid_reg && !rec_chan.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign rec_chan.valid        = valid_reg;
    assign rec_chan.result_kind  = data_reg.result_kind;
    assign rec_chan.region_start = data_reg.region_start;
    assign rec_chan.region_size  = data_reg.region_size;
    assign rec_chan.file_offset  = data_reg.file_offset;
    assign rec_chan.perm_bits    = data_reg.perm_bits;
    assign rec_chan.map_flags    = data_reg.map_flags;
    assign rec_chan.dev_major    = data_reg.dev_major;
    assign rec_chan.dev_minor    = data_reg.dev_minor;
    assign rec_chan.inode_number = data_reg.inode_number;
    assign rec_chan.name_length  = data_reg.name_length;
    assign rec_chan.name_char    = data_reg.name_char;
    assign rec_chan.status       = data_reg.status;

endmodule

`default_nettype wire

>>> rtl/mmlp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mmlp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        result_kind,
    input wire logic [63:0] region_start,
    input wire logic [63:0] region_size,
    input wire logic [2:0]  map_flags,
    input wire logic [9:0]  name_length,
    input wire logic [7:0]  name_char,
    input wire logic [1:0]  status
);
    import mmlp_pkg::*;

    `MMLP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(name_char) && $stable(region_start), "result item changed while stalled")

    `MMLP_ASSERT_NOW(a_echo_clean, out_valid && result_kind == KIND_ECHO, status == ST_OK && region_start == 64'd0 && region_size == 64'd0 && map_flags == 3'd0, "echo item carries record fields")

    `MMLP_ASSERT_NOW(a_fault_clean, out_valid && result_kind == KIND_RECORD && status != ST_OK, region_start == 64'd0 && name_length == 10'd0 && name_char == 8'd0 && map_flags == 3'd0, "end or error record not cleared")

    `MMLP_ASSERT_NOW(a_share_mode, out_valid && result_kind == KIND_RECORD && status == ST_OK, $onehot(map_flags[1:0]) && name_char == 8'd0, "line record with bad sharing flags")

endmodule

bind memory_map_line_parser mmlp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (rec_chan.valid),
    .out_ready    (rec_chan.ready),
    .result_kind  (rec_chan.result_kind),
    .region_start (rec_chan.region_start),
    .region_size  (rec_chan.region_size),
    .map_flags    (rec_chan.map_flags),
    .name_length  (rec_chan.name_length),
    .name_char    (rec_chan.name_char),
    .status       (rec_chan.status)
);

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mmlp_pkg::*;

    localparam int NAME_CAP = NAME_CAPACITY_DEF;

    typedef logic [7:0] text_q_t[$];

    class map_parse_board;
        phase_t      phase;
        logic [63:0] acc;
        logic [63:0] lo_addr;
        logic [63:0] hi_addr;
        logic [63:0] offs;
        logic [31:0] dmaj;
        logic [31:0] dmin;
        logic [2:0]  perms;
        logic        shared;
        logic [12:0] name_cnt;
        result_t     parse_out_q[$];
        int unsigned errors;
        int unsigned seen;

        function new();
            start_line();
            lo_addr = '0;
            hi_addr = '0;
            offs    = '0;
            dmaj    = '0;
            dmin    = '0;
            errors  = 0;
            seen    = 0;
        endfunction

        function int pending();
            return parse_out_q.size();
        endfunction

        function void start_line();
            phase    = PH_START;
            acc      = '0;
            perms    = '0;
            shared   = 1'b0;
            name_cnt = '0;
        endfunction

        function void push_status(logic [1:0] st);
            result_t r;
            r = '0;
            r.result_kind = KIND_RECORD;
            r.status = st;
            parse_out_q.push_back(r);
        endfunction

        function void reject(logic [7:0] c);
            if (c == CH_NL || c == CH_NUL)
                start_line();
            else
                phase = PH_SKIP;
            push_status(ST_BAD);
        endfunction

        function void close_line();
            result_t r;
            r = '0;
            r.result_kind  = KIND_RECORD;
            r.region_start = lo_addr;
            r.region_size  = hi_addr - lo_addr;
            r.file_offset  = offs;
            r.perm_bits    = perms;
            r.map_flags    = {name_cnt == 0, ~shared, shared};
            r.dev_major    = dmaj;
            r.dev_minor    = dmin;
            r.inode_number = acc;
            r.name_length  = name_cnt[9:0];
            r.status       = ST_OK;
            parse_out_q.push_back(r);
            start_line();
        endfunction

        function void name_byte(logic [7:0] c);
            result_t r;
            name_cnt++;
            if (name_cnt >= NAME_CAP)
            begin
                reject(c);
                return;
            end
            phase = PH_NAME;
            r = '0;
            r.result_kind = KIND_ECHO;
            r.name_length = name_cnt[9:0];
            r.name_char   = c;
            parse_out_q.push_back(r);
        endfunction

        function void after_inode(logic [7:0] c);
            if (c == CH_SPACE)
                phase = PH_GAP;
            else if (c == CH_SLASH || c == CH_LBRACK)
                name_byte(c);
            else if (c == CH_NL)
                close_line();
            else
                reject(c);
        endfunction

        function void take_byte(logic [7:0] c);
            logic       is_hex;
            logic       is_dec;
            logic [3:0] nib;
            is_dec = (c >= CH_0 && c <= CH_9);
            is_hex = 1'b1;
            if (is_dec)
                nib = 4'(c - CH_0);
            else if (c >= CH_LA && c <= CH_LF)
                nib = 4'(c - HEX_LOWER_BASE);
            else if (c >= CH_UA && c <= CH_UF)
                nib = 4'(c - HEX_UPPER_BASE);
            else
            begin
                is_hex = 1'b0;
                nib = '0;
            end

            case (phase)
                PH_START:
                    if (is_hex)
                        acc = {acc[59:0], nib};
                    else if (c == CH_DASH)
                    begin
                        lo_addr = acc;
                        acc = '0;
                        phase = PH_END;
                    end
                    else if (c == CH_NUL && acc == 0)
                    begin
                        start_line();
                        push_status(ST_EOD);
                    end
                    else
                        reject(c);
                PH_END:
                    if (is_hex)
                        acc = {acc[59:0], nib};
                    else if (c != CH_SPACE || acc < lo_addr)
                        reject(c);
                    else
                    begin
                        hi_addr = acc;
                        acc = '0;
                        phase = PH_PR;
                    end
                PH_PR:
                    if (c == CH_R || c == CH_DASH)
                    begin
                        if (c == CH_R)
                            perms[0] = 1'b1;
                        phase = PH_PW;
                    end
                    else
                        reject(c);
                PH_PW:
                    if (c == CH_W || c == CH_DASH)
                    begin
                        if (c == CH_W)
                            perms[1] = 1'b1;
                        phase = PH_PX;
                    end
                    else
                        reject(c);
                PH_PX:
                    if (c == CH_X || c == CH_DASH)
                    begin
                        if (c == CH_X)
                            perms[2] = 1'b1;
                        phase = PH_SHARE;
                    end
                    else
                        reject(c);
                PH_SHARE:
                    if (c == CH_S || c == CH_P)
                    begin
                        shared = (c == CH_S);
                        phase = PH_SP;
                    end
                    else
                        reject(c);
                PH_SP:
                    if (c != CH_SPACE)
                        reject(c);
                    else
                    begin
                        acc = '0;
                        phase = PH_OFFSET;
                    end
                PH_OFFSET:
                    if (is_hex)
                        acc = {acc[59:0], nib};
                    else if (c != CH_SPACE)
                        reject(c);
                    else
                    begin
                        offs = acc;
                        acc = '0;
                        phase = PH_MAJOR;
                    end
                PH_MAJOR:
                    if (is_hex)
                        acc = {acc[59:0], nib};
                    else if (c != CH_COLON)
                        reject(c);
                    else
                    begin
                        dmaj = acc[31:0];
                        acc = '0;
                        phase = PH_MINOR;
                    end
                PH_MINOR:
                    if (is_hex)
                        acc = {acc[59:0], nib};
                    else if (c != CH_SPACE)
                        reject(c);
                    else
                    begin
                        dmin = acc[31:0];
                        acc = '0;
                        phase = PH_INODE;
                    end
                PH_INODE:
                    if (is_dec)
                        acc = acc * 64'd10 + 64'(nib);
                    else
                        after_inode(c);
                PH_GAP:
                    after_inode(c);
                PH_NAME:
                    if (c == CH_NL)
                        close_line();
                    else if (c == CH_NUL)
                        reject(c);
                    else
                        name_byte(c);
                PH_SKIP:
                    if (c == CH_NL || c == CH_NUL)
                        start_line();
                default:
                    start_line();
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("tb mismatch: %s", msg);
        endtask

        task diff(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("item %0d %s: got %0h, want %0h", seen, field, got, want));
        endtask

        task match_output(result_t got);
            result_t want;
            if (parse_out_q.size() == 0)
            begin
                report($sformatf("item with nothing pending: kind %0d status %0d",
                                 got.result_kind, got.status));
                return;
            end
            want = parse_out_q.pop_front();
            seen++;
            diff("result_kind", got.result_kind, want.result_kind);
            diff("region_start", got.region_start, want.region_start);
            diff("region_size", got.region_size, want.region_size);
            diff("file_offset", got.file_offset, want.file_offset);
            diff("perm_bits", got.perm_bits, want.perm_bits);
            diff("map_flags", got.map_flags, want.map_flags);
            diff("dev_major", got.dev_major, want.dev_major);
            diff("dev_minor", got.dev_minor, want.dev_minor);
            diff("inode_number", got.inode_number, want.inode_number);
            diff("name_length", got.name_length, want.name_length);
            diff("name_char", got.name_char, want.name_char);
            diff("status", got.status, want.status);
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct = 34;
    int   recv_idle_pct = 65;

    map_parse_board board = new();

    mmlp_byte_if bch();
    mmlp_rec_if  rch();

    memory_map_line_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (bch),
        .rec_chan  (rch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic result_t grab_result();
        return {rch.result_kind, rch.region_start, rch.region_size, rch.file_offset,
                rch.perm_bits, rch.map_flags, rch.dev_major, rch.dev_minor,
                rch.inode_number, rch.name_length, rch.name_char, rch.status};
    endfunction

    // result side
    initial
    begin
        rch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rch.valid && rch.ready)
                board.match_output(grab_result());
            rch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            bch.valid <= 1'b0;
            @(posedge clk);
        end
        bch.valid   <= 1'b1;
        bch.in_byte <= b;
        do
            @(posedge clk);
        while (!bch.ready);
        board.take_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_quiet();
        bch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic void add_text(ref text_q_t q, input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    function automatic logic [63:0] rand_hex_val();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v >> (4 * $urandom_range(0, 15));
    endfunction

    // random letter case, sometimes zero padded or longer than 16 digits
    function automatic string hex_text(logic [63:0] v);
        string s;
        int    pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            s = $sformatf("%0h%016h", $urandom_range(1, 15), v);
        else if (pick == 1)
            s = $sformatf("%016h", v);
        else
            s = $sformatf("%0h", v);
        for (int i = 0; i < s.len(); i++)
            if (s[i] >= CH_LA && s[i] <= CH_LF && $urandom_range(0, 1))
                s[i] = CH_UA + (s[i] - CH_LA);
        return s;
    endfunction

    function automatic string dec_text(int digits);
        string s;
        s = "";
        for (int i = 0; i < digits; i++)
            s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    function automatic text_q_t make_line(bit flip_bounds);
        text_q_t     q;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] t;
        logic [7:0]  ch;
        lo = rand_hex_val();
        hi = lo + (rand_hex_val() >> (4 * $urandom_range(0, 15)));
        if (hi < lo)
            hi = '1;
        if (flip_bounds)
        begin
            t = lo;
            lo = hi;
            hi = t;
        end
        add_text(q, hex_text(lo));
        q.push_back(CH_DASH);
        add_text(q, hex_text(hi));
        q.push_back(CH_SPACE);
        q.push_back($urandom_range(0, 1) ? CH_R : CH_DASH);
        q.push_back($urandom_range(0, 1) ? CH_W : CH_DASH);
        q.push_back($urandom_range(0, 1) ? CH_X : CH_DASH);
        q.push_back($urandom_range(0, 1) ? CH_S : CH_P);
        q.push_back(CH_SPACE);
        add_text(q, hex_text(rand_hex_val()));
        q.push_back(CH_SPACE);
        add_text(q, hex_text(rand_hex_val() >> (4 * $urandom_range(0, 15))));
        q.push_back(CH_COLON);
        add_text(q, hex_text(rand_hex_val() >> (4 * $urandom_range(0, 15))));
        q.push_back(CH_SPACE);
        add_text(q, dec_text($urandom_range(0, 9) == 0 ? $urandom_range(20, 24)
                                                        : $urandom_range(0, 12)));
        repeat ($urandom_range(0, 3)) q.push_back(CH_SPACE);
        if ($urandom_range(0, 9) >= 3)
        begin
            q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_LBRACK);
            repeat ($urandom_range(0, 24))
            begin
                ch = 8'($urandom_range(1, 255));
                if (ch == CH_NL)
                    ch = CH_SPACE;
                q.push_back(ch);
            end
        end
        q.push_back(CH_NL);
        return q;
    endfunction

    task automatic send_long_name(int name_bytes);
        logic [7:0] ch;
        send_text("1-2 r--p 0 0:0 0 /");
        repeat (name_bytes - 1)
        begin
            ch = 8'($urandom_range(1, 255));
            if (ch == CH_NL)
                ch = CH_DASH;
            send_byte(ch);
        end
        send_text("tail\n");
    endtask

    task automatic directed_lines();
        send_byte(CH_NUL);
        send_text("0");
        send_byte(CH_NUL);
        send_text("0-0 ---p 0 0:0 0\n");
        send_text("ffffffffffffffff-FFFFFFFFFFFFFFFF rwxs FfFfFfFfFfFfFfFf ");
        send_text("123456789a:fedcba987 18446744073709551615 /");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_text("\n");
        send_text("123456789abcdef0123-fffffffffffffffff r-xp 0 8:1 ");
        send_text("123456789012345678901234 [heap]\n");
        send_text("1000-2000 -w-p 10 fd:3 42      /tmp/a b\n");
        send_text("1000-1000 --xs 0 0:0 7   \n");
        send_text("2000-1000 r--p 0 0:0 0\n");
        send_text("10+20 r--p 0 0:0 0\n");
        send_text("10-20 rq-p 0 0:0 0\n");
        send_text("10-20 r--x 0 0:0 0\n");
        send_text("10-20 r--p 0 0 0 5\n");
        send_text("10-20 r--p 0 0:0 5 x\n");
        send_text("10-20 r");
        send_byte(CH_NUL);
        send_text("10-20 r--p 0 0:0 5 [x");
        send_byte(CH_NUL);
        // name just under capacity, then one that reaches it
        send_long_name(NAME_CAP - 5);
        send_long_name(NAME_CAP);
        send_text("f-10 rw-p 0 0:0 0\n");
    endtask

    task automatic random_traffic(int byte_goal);
        text_q_t q;
        int      sent;
        int      pick;
        int      cut;
        sent = 0;
        while (sent < byte_goal)
        begin
            pick = $urandom_range(0, 99);
            q = make_line(pick >= 80 && pick < 85);
            if (pick >= 85 && pick < 90)
                q[$urandom_range(0, q.size() - 2)] = 8'($urandom_range(0, 255));
            else if (pick >= 90 && pick < 94)
            begin
                cut = $urandom_range(0, q.size() - 1);
                while (q.size() > cut)
                    void'(q.pop_back());
                q.push_back(CH_NUL);
            end
            else if (pick >= 94 && pick < 98)
            begin
                q.delete();
                repeat ($urandom_range(1, 16)) q.push_back(8'($urandom_range(0, 255)));
                q.push_back(CH_NL);
            end
            else if (pick >= 98)
            begin
                q.delete();
                q.push_back(CH_NUL);
            end
            foreach (q[i])
                send_byte(q[i]);
            sent += q.size();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        bch.valid   = 1'b0;
        bch.in_byte = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_lines();
        random_traffic(400);
        wait_quiet();
        send_idle_pct = 65;
        recv_idle_pct = 34;
        random_traffic(400);
        wait_quiet();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(400);
        wait_quiet();
        if (board.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
